@@ design/register_file_alu_execute_macros.svh @@
// Assertion macros used by the checker file rfae_sva.sv.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef REGISTER_FILE_ALU_EXECUTE_MACROS_SVH
`define REGISTER_FILE_ALU_EXECUTE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RFAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define RFAE_ASSERT_NEVER(lbl, cond, msg) \
  `RFAE_ASSERT(lbl, !(cond), msg)

`endif

@@ design/rfae_pkg.sv @@
`timescale 1ns / 1ps

package rfae_pkg;

  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned REG_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned REG_IDX_W  = 5;
  localparam int unsigned IMM_W      = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DATA_WIDTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MOV_REG = 3'd0,
    FUNC_MOV_IMM = 3'd1,
    FUNC_ADD     = 3'd2,
    FUNC_SUB     = 3'd3,
    FUNC_MUL     = 3'd4,
    FUNC_DIV     = 3'd5,
    FUNC_MOD     = 3'd6
  } func_e;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

@@ design/rfae_if.sv @@
`timescale 1ns / 1ps

interface rfae_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rfae_pkg::FUNC_W-1:0]          func;
  logic [rfae_pkg::REG_IDX_W-1:0]       dest_reg;
  logic [rfae_pkg::REG_IDX_W-1:0]       src_a_reg;
  logic [rfae_pkg::REG_IDX_W-1:0]       src_b_reg;
  logic signed [rfae_pkg::IMM_W-1:0]    immediate;

  modport source (
    output valid, func, dest_reg, src_a_reg, src_b_reg, immediate,
    input  ready
  );
  modport sink (
    input  valid, func, dest_reg, src_a_reg, src_b_reg, immediate,
    output ready
  );
endinterface

interface rfae_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rfae_pkg::OUT_W-1:0]    written_value;
  logic                                 error_code;

  modport source (
    output valid, written_value, error_code,
    input  ready
  );
  modport sink (
    input  valid, written_value, error_code,
    output ready
  );
endinterface

@@ design/rfae_ram.sv @@
`timescale 1ns / 1ps

module rfae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rfae_div.sv @@
`timescale 1ns / 1ps

module rfae_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rfae_pkg::DATA_WIDTH-1:0]     dividend_i,
  input  logic [rfae_pkg::DATA_WIDTH-1:0]     divisor_i,
  output rfae_pkg::div_rsp_t                  rsp_o
);

  localparam int unsigned DW = rfae_pkg::DATA_WIDTH;
  localparam int unsigned CW = rfae_pkg::DIV_CNT_W;

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q && (cnt_q != '0)) begin
      cnt_q <= cnt_q - CW'(1);
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign rsp_o.done      = busy_q && (cnt_q == '0);
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ design/register_file_alu_execute.sv @@
`timescale 1ns / 1ps

// Channel   Port    Dir  Contents
// request   req_i   in   func, dest_reg, src_a_reg, src_b_reg, immediate
// result    rsp_o   out  written_value, error_code
//
// One request at a time: moves, add, sub and mul pass through S_EXEC and S_WB,
// and div and mod by a nonzero divisor also wait in S_DIV for the radix-2 divider.
// A request is taken only when the unit is idle; the result register lets the
// next request in while the previous result waits. A stalled result holds the
// write back and the register file. Reset clears the file through valid bits.

module register_file_alu_execute (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfae_in_if.sink   req_i,
  rfae_out_if.source rsp_o
);

  localparam int unsigned DW = rfae_pkg::DATA_WIDTH;
  localparam int unsigned AW = rfae_pkg::REG_AW;
  localparam int unsigned NR = rfae_pkg::NUM_REGS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [NR-1:0]                 vld_q;
  logic                          out_valid_q;
  logic [rfae_pkg::OUT_W-1:0]    out_value_q;
  logic                          out_err_q;

  logic [rfae_pkg::FUNC_W-1:0]   func_q;
  logic [AW-1:0]                 dest_q;
  logic                          dest_ok_q;
  logic [DW-1:0]                 imm_q;
  logic                          vld_a_q, vld_b_q;
  logic [DW-1:0]                 res_q, res_d;
  logic                          err_q, err_d;
  logic                          we_q, we_d;
  logic                          a_neg_q, b_neg_q;
  logic [DW-1:0]                 b_q;

  logic                          accept;
  logic                          wb_fire;
  logic                          ram_we;
  logic [AW-1:0]                 addr_a, addr_b;
  logic                          ok_a, ok_b;
  logic [DW-1:0]                 rdata_a, rdata_b;
  logic [DW-1:0]                 a_v, b_v;
  logic [DW-1:0]                 a_mag, b_mag;
  logic [DW-1:0]                 prod;
  logic [DW-1:0]                 rem_s;
  logic                          div_start;
  rfae_pkg::div_rsp_t            div_rsp;

  assign accept  = req_i.valid && req_i.ready;
  assign wb_fire = (state_q == S_WB) && (!out_valid_q || rsp_o.ready);
  assign ram_we  = wb_fire && we_q && dest_ok_q;

  assign addr_a = AW'(req_i.src_a_reg);
  assign addr_b = AW'(req_i.src_b_reg);
  assign ok_a   = (32'(req_i.src_a_reg) < 32'(NR));
  assign ok_b   = (32'(req_i.src_b_reg) < 32'(NR));

  rfae_ram #(.WIDTH(DW), .DEPTH(NR)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dest_q),
    .wdata_i (res_q),
    .re_i    (accept),
    .raddr_i (addr_a),
    .rdata_o (rdata_a)
  );

  rfae_ram #(.WIDTH(DW), .DEPTH(NR)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dest_q),
    .wdata_i (res_q),
    .re_i    (accept),
    .raddr_i (addr_b),
    .rdata_o (rdata_b)
  );

  assign a_v   = vld_a_q ? rdata_a : '0;
  assign b_v   = vld_b_q ? rdata_b : '0;
  assign a_mag = a_v[DW-1] ? (DW'(0) - a_v) : a_v;
  assign b_mag = b_v[DW-1] ? (DW'(0) - b_v) : b_v;
  assign prod  = DW'(a_v * b_v);

  assign rem_s = a_neg_q ? (DW'(0) - div_rsp.remainder) : div_rsp.remainder;

  rfae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_mag),
    .divisor_i  (b_mag),
    .rsp_o      (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    err_d     = err_q;
    we_d      = we_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        err_d   = 1'b0;
        we_d    = 1'b1;
        state_d = S_WB;
        case (func_q)
          rfae_pkg::FUNC_MOV_REG: res_d = a_v;
          rfae_pkg::FUNC_MOV_IMM: res_d = imm_q;
          rfae_pkg::FUNC_ADD:     res_d = a_v + b_v;
          rfae_pkg::FUNC_SUB:     res_d = a_v - b_v;
          rfae_pkg::FUNC_MUL:     res_d = prod;
          rfae_pkg::FUNC_DIV, rfae_pkg::FUNC_MOD: begin
            if (b_v == '0) begin
              err_d = 1'b1;
              we_d  = 1'b0;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: we_d = 1'b0;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_WB;
          if (func_q == rfae_pkg::FUNC_DIV) begin
            res_d = (a_neg_q != b_neg_q) ? (DW'(0) - div_rsp.quotient) : div_rsp.quotient;
          end else begin
            res_d = rem_s[DW-1] ? (rem_s + b_q) : rem_s;
          end
        end
      end
      S_WB: begin
        if (wb_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        vld_q[dest_q] <= 1'b1;
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= req_i.func;
      dest_q    <= AW'(req_i.dest_reg);
      dest_ok_q <= (32'(req_i.dest_reg) < 32'(NR));
      imm_q     <= DW'(req_i.immediate);
      vld_a_q   <= ok_a && vld_q[addr_a];
      vld_b_q   <= ok_b && vld_q[addr_b];
    end
    if (div_start) begin
      a_neg_q <= a_v[DW-1];
      b_neg_q <= b_v[DW-1];
      b_q     <= b_v;
    end
    res_q <= res_d;
    err_q <= err_d;
    we_q  <= we_d;
    if (wb_fire) begin
      out_value_q <= we_q ? rfae_pkg::OUT_W'($signed(res_q)) : '0;
      out_err_q   <= err_q;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.written_value = out_value_q;
  assign rsp_o.error_code    = out_err_q;

endmodule

@@ design/rfae_sva.sv @@
`timescale 1ns / 1ps
`include "register_file_alu_execute_macros.svh"

module rfae_sva (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic [rfae_pkg::OUT_W-1:0]       rsp_written_value_i,
  input logic                             rsp_error_code_i
);

  // A stalled result keeps its valid and its payload.
  `RFAE_ASSERT(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i, "result dropped")
  `RFAE_ASSERT(a_rsp_stable, (rsp_valid_i && !rsp_ready_i) |=> ($stable(rsp_written_value_i) && $stable(rsp_error_code_i)), "result changed while stalled")

  // A divide by zero reports no written value.
  `RFAE_ASSERT_NEVER(a_err_zero, rsp_valid_i && rsp_error_code_i && (rsp_written_value_i != '0), "error result carries a value")

  // Only one request is in flight, and its result never shows on the next edge.
  `RFAE_ASSERT(a_one_req, (req_valid_i && req_ready_i) |=> !req_ready_i, "second request taken while busy")
  `RFAE_ASSERT(a_no_early_rsp, (req_valid_i && req_ready_i) |=> !$rose(rsp_valid_i), "result appeared too early")

endmodule

bind register_file_alu_execute rfae_sva u_rfae_sva (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_written_value_i (rsp_o.written_value),
  .rsp_error_code_i    (rsp_o.error_code)
);
